// ===== sv/ptrc_pkg.sv =====
package ptrc_pkg;

  // Table geometry
  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LIVE_W   = $clog2(CAPACITY + 1);
  localparam int SCAN_W   = $clog2(CAPACITY + 1);

  localparam int MAXE_W = 7;
  localparam logic [MAXE_W-1:0] MAXE_RESET = 7'd64;

  localparam logic [7:0] REFS_INIT = 8'd2;
  localparam logic [7:0] REFS_MAX  = 8'hFF;

  // Operation codes
  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_LK_TUN   = 3'd1;
  localparam logic [2:0] OP_LK_REAL  = 3'd2;
  localparam logic [2:0] OP_ACQUIRE  = 3'd3;
  localparam logic [2:0] OP_RELEASE  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND  = 3'd2;
  localparam logic [2:0] ST_BADHANDLE = 3'd3;
  localparam logic [2:0] ST_SAT       = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] tunnel_ip;
    logic [31:0] real_ip;
    logic [15:0] real_port;
    logic [5:0]  handle;
  } ptrc_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
    logic [7:0] count_after;
    logic       freed;
  } ptrc_out_t;

  // One table entry as stored in the entry RAM
  typedef struct packed {
    logic [31:0]       tunnel_ip;
    logic [31:0]       real_ip;
    logic [15:0]       real_port;
    logic [7:0]        refs;
    logic [SLOT_W-1:0] rank;
  } ptrc_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    ptrc_entry_t       wdata;
    logic [SLOT_W-1:0] raddr;
  } ptrc_ram_req_t;

endpackage

// ===== sv/peer_table_refcount_unit.sv =====
// Peer table with reference counts: up to 64 entries of tunnel IP, real IP + UDP port and
// an 8-bit count, all held in one entry RAM (one read and one write port, registered
// read data). One item is worked at a time. Acquire, release without free, and a lookup
// that hits its last-hit cache pass through S_CHK and then S_RESP before out_valid rises;
// a refused add, a bad handle or an unknown op go straight to S_RESP. Add and a lookup
// with no cached slot, a lookup that misses a valid cache, and a release that frees its
// entry each make one full pass over the entry RAM, one read per cycle. The next item is
// taken in the cycle after the result moves to the output register. A result sits in an
// output register, so the next item is taken while the last result waits. A full output
// register holds the controller until out_ready. max_entries may only be written while
// the block is idle. Entries become visible to lookups only once added; the entry RAM
// needs no clearing.
module peer_table_refcount_unit
  import ptrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptrc_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ptrc_out_t         out_data,
  input  logic              cfg_we,
  input  logic [MAXE_W-1:0] cfg_wdata
);

  logic [MAXE_W-1:0] cfg_max_r;
  logic              out_valid_r, out_valid_nxt;
  ptrc_out_t         out_data_r, out_data_nxt;

  logic              rsp_valid;
  logic              rsp_ready;
  ptrc_out_t         rsp_data;
  ptrc_ram_req_t     ram_req;
  ptrc_entry_t       ram_rdata;

  // max_entries register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_max_r <= MAXE_RESET;
    end else if (cfg_we) begin
      cfg_max_r <= cfg_wdata;
    end
  end

  ptrc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_entries (cfg_max_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_data    (rsp_data),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  ptrc_entry_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign rsp_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rsp_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped or changed while stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid && out_valid_r && !out_ready) |-> !rsp_ready)
    else $error("pending result would be overwritten");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid && rsp_ready) |=> !rsp_valid)
    else $error("controller offered the same result twice");

endmodule

// ===== sv/ptrc_entry_ram.sv =====
module ptrc_entry_ram
  import ptrc_pkg::*;
(
  input  logic          clk,
  input  ptrc_ram_req_t req,
  output ptrc_entry_t   rdata
);

  ptrc_entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ===== sv/ptrc_ctrl.sv =====
module ptrc_ctrl
  import ptrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MAXE_W-1:0] max_entries,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptrc_in_t          in_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ptrc_out_t         rsp_data,
  output ptrc_ram_req_t     ram_req,
  input  ptrc_entry_t       ram_rdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ADD_SCAN = 3'd1;
  localparam logic [2:0] S_SRCH     = 3'd2;
  localparam logic [2:0] S_CHK      = 3'd3;
  localparam logic [2:0] S_REL_SCAN = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  // control state
  logic [2:0]          state_r, state_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [LIVE_W-1:0]   live_r, live_nxt;
  logic                tc_v_r, tc_v_nxt;
  logic                rc_v_r, rc_v_nxt;
  logic [SCAN_W-1:0]   scan_r, scan_nxt;
  logic                pend_r, pend_nxt;
  logic                found_r, found_nxt;

  // payload
  ptrc_in_t            req_r, req_nxt;
  logic [SLOT_W-1:0]   tc_slot_r, tc_slot_nxt;
  logic [SLOT_W-1:0]   rc_slot_r, rc_slot_nxt;
  logic [SLOT_W-1:0]   pidx_r, pidx_nxt;
  logic [SLOT_W-1:0]   best_idx_r, best_idx_nxt;
  logic [SLOT_W-1:0]   best_rank_r, best_rank_nxt;
  ptrc_entry_t         best_word_r, best_word_nxt;
  logic [SLOT_W-1:0]   rel_rank_r, rel_rank_nxt;
  ptrc_out_t           res_r, res_nxt;

  logic                scan_done;
  logic                key_hit;
  logic                do_bump;
  ptrc_entry_t         bump_word;
  ptrc_entry_t         new_word;

  assign in_ready  = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_RESP);
  assign rsp_data  = res_r;
  assign scan_done = (scan_r == SCAN_W'(CAPACITY)) && !pend_r;

  // key compare against the word on the RAM read port
  always_comb begin
    if (req_r.op == OP_LK_TUN) begin
      key_hit = (ram_rdata.tunnel_ip == req_r.tunnel_ip);
    end else begin
      key_hit = (ram_rdata.real_ip == req_r.real_ip) &&
                (ram_rdata.real_port == req_r.real_port);
    end
  end

  assign bump_word = (state_r == S_SRCH) ? best_word_r : ram_rdata;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    live_nxt      = live_r;
    tc_v_nxt      = tc_v_r;
    rc_v_nxt      = rc_v_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    req_nxt       = req_r;
    tc_slot_nxt   = tc_slot_r;
    rc_slot_nxt   = rc_slot_r;
    pidx_nxt      = pidx_r;
    best_idx_nxt  = best_idx_r;
    best_rank_nxt = best_rank_r;
    best_word_nxt = best_word_r;
    rel_rank_nxt  = rel_rank_r;
    res_nxt       = res_r;
    do_bump       = 1'b0;
    new_word      = ram_rdata;

    ram_req       = '0;
    ram_req.raddr = scan_r[SLOT_W-1:0];

    // sweep pointer, shared by all scan states
    if (state_r == S_ADD_SCAN || state_r == S_SRCH || state_r == S_REL_SCAN) begin
      pend_nxt = (scan_r < SCAN_W'(CAPACITY));
      pidx_nxt = scan_r[SLOT_W-1:0];
      if (scan_r < SCAN_W'(CAPACITY)) begin
        scan_nxt = scan_r + SCAN_W'(1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          res_nxt   = '0;
          case (in_data.op)
            OP_ADD: begin
              if (32'(live_r) >= 32'(max_entries) || live_r == LIVE_W'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_ADD_SCAN;
              end
            end
            OP_LK_TUN: begin
              best_idx_nxt  = tc_slot_r;
              ram_req.raddr = tc_slot_r;
              state_nxt     = tc_v_r ? S_CHK : S_SRCH;
            end
            OP_LK_REAL: begin
              best_idx_nxt  = rc_slot_r;
              ram_req.raddr = rc_slot_r;
              state_nxt     = rc_v_r ? S_CHK : S_SRCH;
            end
            OP_ACQUIRE, OP_RELEASE: begin
              best_idx_nxt  = in_data.handle[SLOT_W-1:0];
              ram_req.raddr = in_data.handle[SLOT_W-1:0];
              if (valid_r[in_data.handle[SLOT_W-1:0]]) begin
                state_nxt = S_CHK;
              end else begin
                res_nxt.status = ST_BADHANDLE;
                state_nxt      = S_RESP;
              end
            end
            default: begin
              res_nxt.status = ST_NOTFOUND;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end

      // age every live entry by one, note the lowest free slot
      S_ADD_SCAN: begin
        if (pend_r) begin
          if (valid_r[pidx_r]) begin
            new_word.rank = ram_rdata.rank + SLOT_W'(1);
            ram_req.we    = 1'b1;
            ram_req.waddr = pidx_r;
            ram_req.wdata = new_word;
          end else if (!found_r) begin
            found_nxt    = 1'b1;
            best_idx_nxt = pidx_r;
          end
        end
        if (scan_done) begin
          new_word.tunnel_ip = req_r.tunnel_ip;
          new_word.real_ip   = req_r.real_ip;
          new_word.real_port = req_r.real_port;
          new_word.refs      = REFS_INIT;
          new_word.rank      = '0;
          ram_req.we         = 1'b1;
          ram_req.waddr      = best_idx_r;
          ram_req.wdata      = new_word;
          valid_nxt[best_idx_r] = 1'b1;
          live_nxt           = live_r + LIVE_W'(1);
          res_nxt.status      = ST_OK;
          res_nxt.slot        = 6'(best_idx_r);
          res_nxt.count_after = REFS_INIT;
          res_nxt.freed       = 1'b0;
          state_nxt          = S_RESP;
        end
      end

      // newest match = lowest age rank
      S_SRCH: begin
        if (pend_r && valid_r[pidx_r] && key_hit &&
            (!found_r || ram_rdata.rank < best_rank_r)) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = pidx_r;
          best_rank_nxt = ram_rdata.rank;
          best_word_nxt = ram_rdata;
        end
        if (scan_done) begin
          if (!found_r) begin
            res_nxt   = '0;
            res_nxt.status = ST_NOTFOUND;
            state_nxt = S_RESP;
          end else begin
            if (req_r.op == OP_LK_TUN) begin
              tc_v_nxt    = 1'b1;
              tc_slot_nxt = best_idx_r;
            end else begin
              rc_v_nxt    = 1'b1;
              rc_slot_nxt = best_idx_r;
            end
            do_bump = 1'b1;
          end
        end
      end

      // word for cache slot or handle is on the read port
      S_CHK: begin
        case (req_r.op)
          OP_LK_TUN, OP_LK_REAL: begin
            if (valid_r[best_idx_r] && key_hit) begin
              do_bump = 1'b1;
            end else begin
              state_nxt = S_SRCH;
            end
          end
          OP_ACQUIRE: begin
            do_bump = 1'b1;
          end
          OP_RELEASE: begin
            res_nxt.status = ST_OK;
            res_nxt.slot   = 6'(best_idx_r);
            if (ram_rdata.refs <= 8'd1) begin
              valid_nxt[best_idx_r] = 1'b0;
              tc_v_nxt     = 1'b0;
              rc_v_nxt     = 1'b0;
              if (live_r != '0) begin
                live_nxt = live_r - LIVE_W'(1);
              end
              rel_rank_nxt        = ram_rdata.rank;
              res_nxt.count_after = '0;
              res_nxt.freed       = 1'b1;
              state_nxt           = S_REL_SCAN;
            end else begin
              new_word.refs       = ram_rdata.refs - 8'd1;
              ram_req.we          = 1'b1;
              ram_req.waddr       = best_idx_r;
              ram_req.wdata       = new_word;
              res_nxt.count_after = new_word.refs;
              res_nxt.freed       = 1'b0;
              state_nxt           = S_RESP;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      // close the gap left in the age order
      S_REL_SCAN: begin
        if (pend_r && valid_r[pidx_r] && ram_rdata.rank > rel_rank_r) begin
          new_word.rank = ram_rdata.rank - SLOT_W'(1);
          ram_req.we    = 1'b1;
          ram_req.waddr = pidx_r;
          ram_req.wdata = new_word;
        end
        if (scan_done) begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // saturating increment of the reference count in slot best_idx_r
    if (do_bump) begin
      res_nxt.slot  = 6'(best_idx_r);
      res_nxt.freed = 1'b0;
      if (bump_word.refs == REFS_MAX) begin
        res_nxt.status      = ST_SAT;
        res_nxt.count_after = REFS_MAX;
      end else begin
        new_word            = bump_word;
        new_word.refs       = bump_word.refs + 8'd1;
        ram_req.we          = 1'b1;
        ram_req.waddr       = best_idx_r;
        ram_req.wdata       = new_word;
        res_nxt.status      = ST_OK;
        res_nxt.count_after = new_word.refs;
      end
      state_nxt = S_RESP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      live_r  <= '0;
      tc_v_r  <= 1'b0;
      rc_v_r  <= 1'b0;
      scan_r  <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      live_r  <= live_nxt;
      tc_v_r  <= tc_v_nxt;
      rc_v_r  <= rc_v_nxt;
      scan_r  <= scan_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    tc_slot_r   <= tc_slot_nxt;
    rc_slot_r   <= rc_slot_nxt;
    pidx_r      <= pidx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_rank_r <= best_rank_nxt;
    best_word_r <= best_word_nxt;
    rel_rank_r  <= rel_rank_nxt;
    res_r       <= res_nxt;
  end

  a_live_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    LIVE_W'($countones(valid_r)) == live_r)
    else $error("live count out of step with valid bits");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !ram_req.we)
    else $error("entry RAM written outside an operation");

  a_resp_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid && rsp_ready) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after handing off result");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_SCAN && scan_done) |=> (live_r == $past(live_r) + LIVE_W'(1)))
    else $error("add did not grow the live count");

endmodule
